>>> design/wbcs_pkg.sv
package wbcs_pkg;

	localparam int COL_W = 12;
	localparam int CNT_W = 21;
	localparam int SUM_W = 32;
	localparam int FW_W = 13;
	localparam int LVL_W = 8;
	localparam int QUO_STEPS = COL_W;
	localparam logic [CNT_W-1:0] MAX_FRAME_PIXELS = CNT_W'(1048576);

	// Reciprocal of three scaled by 2^17, rounded up.
	localparam logic [15:0] RECIP3 = 16'd43691;

	localparam logic CFG_FRAME_WIDTH = 1'b0;
	localparam logic CFG_WHITE_LEVEL = 1'b1;

	typedef enum logic [1:0] {
		STEER_REVERSE = 2'd0,
		STEER_LEFT    = 2'd1,
		STEER_RIGHT   = 2'd2,
		STEER_FORWARD = 2'd3
	} steer_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} frame_job_t;

	typedef struct packed {
		logic       push;
		frame_job_t job;
	} job_req_t;

	// Floor of x / 3, exact for every x below 2^14, the whole input range.
	function automatic logic [FW_W-1:0] div3(input logic [FW_W:0] x);
		logic [29:0] p;
		p = 30'(x) * 30'(RECIP3);
		return p[29:17];
	endfunction

endpackage

>>> design/wbcs_front.sv
module wbcs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [wbcs_pkg::LVL_W-1:0] white_level,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic [wbcs_pkg::COL_W-1:0] column,
	input  logic                      frame_end,
	output wbcs_pkg::job_req_t        req
);
	import wbcs_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic             white;
	logic [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0] count_next;

	always_comb begin
		white = (red == white_level) && (green == white_level) && (blue == white_level)
			&& (count_q < MAX_FRAME_PIXELS);
		sum_next = white ? sum_q + SUM_W'(column) : sum_q;
		count_next = white ? count_q + CNT_W'(1) : count_q;
		req.push = accept && frame_end;
		req.job.sum = sum_next;
		req.job.count = count_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				sum_q <= '0;
				count_q <= '0;
			end else begin
				sum_q <= sum_next;
				count_q <= count_next;
			end
		end
	end

endmodule

>>> design/wbcs_queue.sv
module wbcs_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wbcs_pkg::job_req_t    req,
	input  logic                  pop,
	output logic                  full,
	output logic                  empty,
	output wbcs_pkg::frame_job_t  job_out
);
	import wbcs_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	frame_job_t         entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     fill_q;
	logic               do_push;
	logic               do_pop;

	assign full = (fill_q == (PTR_W+1)'(DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = req.push && !full;
	assign do_pop = pop && !empty;
	assign job_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= req.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

>>> design/wbcs_back.sv
module wbcs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [wbcs_pkg::FW_W-1:0]  frame_width,
	input  logic                       job_empty,
	input  wbcs_pkg::frame_job_t       job,
	output logic                       job_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic [1:0]                 steer_code,
	output logic [wbcs_pkg::COL_W-1:0] centroid_column,
	output logic [wbcs_pkg::CNT_W-1:0] white_total
);
	import wbcs_pkg::*;

	localparam int STEP_W = $clog2(QUO_STEPS + 1);

	back_state_t       state_q;
	back_state_t       state_next;
	logic [CNT_W-1:0]  rem_q;
	logic [COL_W-1:0]  dvd_q;
	logic [COL_W-1:0]  quot_q;
	logic [CNT_W-1:0]  divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [1:0]        out_code_q;
	logic [COL_W-1:0]  out_centre_q;
	logic [CNT_W-1:0]  out_total_q;

	logic [CNT_W:0]    trial;
	logic              fits;
	logic [CNT_W-1:0]  rem_next;
	logic [FW_W-1:0]   lo_thresh;
	logic [FW_W-1:0]   hi_thresh;
	steer_t            code;
	logic              out_free;
	logic              load_job;
	logic              emit;

	assign empty = !out_valid_q;
	assign steer_code = out_code_q;
	assign centroid_column = out_centre_q;
	assign white_total = out_total_q;
	assign out_free = !out_valid_q || pop;

	// One restoring division step: the quotient is known to fit in COL_W bits, since
	// every summed column is below 2^COL_W.
	always_comb begin
		trial = {rem_q, dvd_q[COL_W-1]};
		fits = trial >= {1'b0, divisor_q};
		rem_next = fits ? CNT_W'(trial - {1'b0, divisor_q}) : CNT_W'(trial);
	end

	always_comb begin
		lo_thresh = div3({1'b0, frame_width});
		hi_thresh = div3({frame_width, 1'b0});
		if (divisor_q == '0) begin
			code = STEER_REVERSE;
		end else if ({1'b0, quot_q} < lo_thresh) begin
			code = STEER_LEFT;
		end else if ({1'b0, quot_q} > hi_thresh) begin
			code = STEER_RIGHT;
		end else begin
			code = STEER_FORWARD;
		end
	end

	always_comb begin
		state_next = state_q;
		load_job = 1'b0;
		emit = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					load_job = 1'b1;
					state_next = (job.count == '0) ? BK_EMIT : BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(QUO_STEPS - 1)) begin
					state_next = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					state_next = BK_IDLE;
				end
			end
			default: begin
				state_next = BK_IDLE;
			end
		endcase
		job_pop = load_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			rem_q <= CNT_W'(job.sum[SUM_W-1:COL_W]);
			dvd_q <= job.sum[COL_W-1:0];
			quot_q <= '0;
			divisor_q <= job.count;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[COL_W-2:0], 1'b0};
			quot_q <= {quot_q[COL_W-2:0], fits};
			step_q <= step_q + STEP_W'(1);
		end
		if (emit) begin
			out_code_q <= code;
			out_centre_q <= quot_q;
			out_total_q <= divisor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> design/white_blob_centroid_steering.sv
// Bright pixel centroid tracker. Pixels are taken one per clock cycle (push while full is
// low); those whose three channels all equal white_level are counted and their columns
// summed. The pixel flagged frame_end closes the frame and produces one request on the
// result side: the floor of the mean white column, the white count and a steering code
// (reverse with no white pixel, left below frame_width/3, right above 2*frame_width/3,
// forward otherwise). Each frame's totals wait in a two-entry queue for the divider,
// which loads a frame, works out twelve quotient bits and then emits, skipping the
// division for a frame with no white pixel. So full only rises when short frames follow
// each other faster than the divider clears them or when results are not popped. Register
// writes must only be made while no frame is in flight.
module white_blob_centroid_steering (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [11:0] column,
	input  logic        frame_end,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  steer_code,
	output logic [11:0] centroid_column,
	output logic [20:0] white_total
);
	import wbcs_pkg::*;

	logic [FW_W-1:0]  frame_width_q;
	logic [LVL_W-1:0] white_level_q;
	logic             accept;
	job_req_t         req;
	logic             job_empty;
	logic             job_pop;
	frame_job_t       job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FW_W'(640);
			white_level_q <= LVL_W'(255);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data;
				CFG_WHITE_LEVEL: white_level_q <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	wbcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.white_level (white_level_q),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.column      (column),
		.frame_end   (frame_end),
		.req         (req)
	);

	wbcs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.pop     (job_pop),
		.full    (full),
		.empty   (job_empty),
		.job_out (job)
	);

	wbcs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_width     (frame_width_q),
		.job_empty       (job_empty),
		.job             (job),
		.job_pop         (job_pop),
		.pop             (pop),
		.empty           (empty),
		.steer_code      (steer_code),
		.centroid_column (centroid_column),
		.white_total     (white_total)
	);

endmodule

>>> design/wbcs_checker.sv
module wbcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pop,
	input logic        empty,
	input logic [1:0]  steer_code,
	input logic [11:0] centroid_column,
	input logic [20:0] white_total
);
	import wbcs_pkg::*;

	// A waiting result must not change or vanish until it is popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(steer_code) && $stable(centroid_column)
			&& $stable(white_total)))
		else $error("waiting result changed before pop");

	// A frame with no white pixel must report reverse and a zero centroid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && white_total == '0) |-> (steer_code == STEER_REVERSE
			&& centroid_column == '0))
		else $error("empty frame not reported as reverse");

	// Reverse is reserved for frames without white pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && white_total != '0) |-> (steer_code != STEER_REVERSE))
		else $error("reverse given for a frame with white pixels");

	// The white count is capped.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (white_total <= MAX_FRAME_PIXELS))
		else $error("white count above cap");

endmodule

bind white_blob_centroid_steering wbcs_checker u_wbcs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pop             (pop),
	.empty           (empty),
	.steer_code      (steer_code),
	.centroid_column (centroid_column),
	.white_total     (white_total)
);
